FILE: hw/rtl/dtq_pkg.sv
// Shared types, codes and constants of the deadline timer queue.
package dtq_pkg;

  localparam int N_TIMERS_DEF = 16;
  localparam int TIME_W = 63;
  localparam int IV_W = 32;
  localparam int ID_W = 16;
  localparam int DLY_W = 20;
  localparam int ENT_W = TIME_W + IV_W + ID_W;
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_MIN_DELAY = 3'd0;
  localparam logic [DLY_W-1:0] MIN_DELAY_RST = 20'd100;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SM_ADD,
    SM_CAN,
    SM_PEND,
    SM_SEL,
    SM_MIN
  } scan_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_RESP,
    S_CAN_SCAN,
    S_CAN_RESP,
    S_PEND_SCAN,
    S_SEL_SCAN,
    S_SEL_CHK,
    S_EMIT,
    S_MIN_SCAN,
    S_TICK_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    scan_mode_t mode;
    logic add_commit;
    logic can_commit;
    logic emit;
    logic tick_done;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic best_v;
  } dp_stat_t;

endpackage

FILE: hw/rtl/deadline_timer_queue_unit.sv
// Top level of the deadline timer queue: register port, controller and datapath.
//
// The block keeps a table of up to N_TIMERS timers (id, deadline, interval).
// Input transactions carry a command: add, cancel or tick with the current time.
// An add or cancel yields one result transaction; a tick yields one transaction
// per expired timer, ordered by deadline and then id, and a final tick-done
// transaction with the next deadline and the reload delay. out_last marks the
// final result of each input. Command code 3 is taken and dropped silently.
// Every command scans the table through one read port of the table memory, one
// entry per cycle. A tick runs a pending scan, one selection scan per expiring
// timer and a last one that finds none, then a scan for the next deadline.
// The block holds one command at a time; in_ready is high only while it is idle.
// The result register lets the next command be accepted while the last result
// still waits; while out_ready is low, the block stalls before the next result.
// Synchronous reset empties the table and sets min_delay_us to 100; no
// clearing pass is needed. min_delay_us is written over the APB-style port at
// byte address 0 and should only be changed while the block is idle.
module deadline_timer_queue_unit #(
  parameter int N_TIMERS = dtq_pkg::N_TIMERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic [dtq_pkg::ID_W-1:0]          in_timer_id,
  input  logic [dtq_pkg::TIME_W-1:0]        in_time_us,
  input  logic [dtq_pkg::IV_W-1:0]          in_interval_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [dtq_pkg::ID_W-1:0]          out_timer_id,
  output logic [1:0]                        out_status,
  output logic                              out_earliest_changed,
  output logic                              out_next_valid,
  output logic [dtq_pkg::TIME_W-1:0]        out_next_deadline,
  output logic [dtq_pkg::TIME_W-1:0]        out_reload_delay,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dtq_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  dtq_pkg::ctl_cmd_t cmd;
  dtq_pkg::dp_stat_t stat;
  logic [dtq_pkg::DLY_W-1:0] min_delay_r;

  // Configuration register; writes to other addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delay_r <= dtq_pkg::MIN_DELAY_RST;
    end else if (psel && penable && pwrite && paddr == dtq_pkg::REG_MIN_DELAY) begin
      min_delay_r <= pwdata[dtq_pkg::DLY_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == dtq_pkg::REG_MIN_DELAY) ? 32'(min_delay_r) : '0;

  dtq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_command(in_command),
    .in_ready(in_ready), .stat(stat), .cmd(cmd)
  );

  dtq_dp #(.N_TIMERS(N_TIMERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_timer_id(in_timer_id), .in_time_us(in_time_us), .in_interval_us(in_interval_us),
    .min_delay(min_delay_r), .out_ready(out_ready), .out_valid(out_valid),
    .out_kind(out_kind), .out_timer_id(out_timer_id), .out_status(out_status),
    .out_earliest_changed(out_earliest_changed), .out_next_valid(out_next_valid),
    .out_next_deadline(out_next_deadline), .out_reload_delay(out_reload_delay),
    .out_last(out_last)
  );

`ifndef NO_ASSERTIONS
  // A real command keeps the block busy in the following cycle.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == dtq_pkg::CMD_ADD ||
     in_command == dtq_pkg::CMD_CANCEL || in_command == dtq_pkg::CMD_TICK)) |=> !in_ready)
    else $error("block idle right after accepting a command");

  // A scan only finishes while a command is in progress.
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scan_done |-> !in_ready)
    else $error("scan completed while idle");

  // An expiry is only emitted for a selected timer.
  a_emit_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.best_v)
    else $error("expiry emitted without a selected timer");
`endif
endmodule

FILE: hw/rtl/dtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: hw/rtl/dtq_ctrl.sv
// Controller state machine that sequences table scans and results.
module dtq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  output logic               in_ready,
  input  dtq_pkg::dp_stat_t  stat,
  output dtq_pkg::ctl_cmd_t  cmd
);
  dtq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_command == dtq_pkg::CMD_ADD) state_nxt = dtq_pkg::S_ADD_SCAN;
          else if (in_command == dtq_pkg::CMD_CANCEL) state_nxt = dtq_pkg::S_CAN_SCAN;
          else if (in_command == dtq_pkg::CMD_TICK) state_nxt = dtq_pkg::S_PEND_SCAN;
        end
      end
      dtq_pkg::S_ADD_SCAN: if (stat.scan_done) state_nxt = dtq_pkg::S_ADD_RESP;
      dtq_pkg::S_ADD_RESP: if (stat.out_free) state_nxt = dtq_pkg::S_IDLE;
      dtq_pkg::S_CAN_SCAN: if (stat.scan_done) state_nxt = dtq_pkg::S_CAN_RESP;
      dtq_pkg::S_CAN_RESP: if (stat.out_free) state_nxt = dtq_pkg::S_IDLE;
      dtq_pkg::S_PEND_SCAN: if (stat.scan_done) state_nxt = dtq_pkg::S_SEL_SCAN;
      dtq_pkg::S_SEL_SCAN: if (stat.scan_done) state_nxt = dtq_pkg::S_SEL_CHK;
      dtq_pkg::S_SEL_CHK: begin
        state_nxt = stat.best_v ? dtq_pkg::S_EMIT : dtq_pkg::S_MIN_SCAN;
      end
      dtq_pkg::S_EMIT: if (stat.out_free) state_nxt = dtq_pkg::S_SEL_SCAN;
      dtq_pkg::S_MIN_SCAN: if (stat.scan_done) state_nxt = dtq_pkg::S_TICK_RESP;
      dtq_pkg::S_TICK_RESP: if (stat.out_free) state_nxt = dtq_pkg::S_IDLE;
      default: state_nxt = dtq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mode = dtq_pkg::SM_ADD;
    in_ready = 1'b0;
    case (state_r)
      dtq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == dtq_pkg::CMD_ADD) begin
            cmd.scan_start = 1'b1;
            cmd.mode = dtq_pkg::SM_ADD;
          end else if (in_command == dtq_pkg::CMD_CANCEL) begin
            cmd.scan_start = 1'b1;
            cmd.mode = dtq_pkg::SM_CAN;
          end else if (in_command == dtq_pkg::CMD_TICK) begin
            cmd.scan_start = 1'b1;
            cmd.mode = dtq_pkg::SM_PEND;
          end
        end
      end
      dtq_pkg::S_ADD_RESP: cmd.add_commit = stat.out_free;
      dtq_pkg::S_CAN_RESP: cmd.can_commit = stat.out_free;
      dtq_pkg::S_PEND_SCAN: begin
        cmd.scan_start = stat.scan_done;
        cmd.mode = dtq_pkg::SM_SEL;
      end
      dtq_pkg::S_SEL_CHK: begin
        cmd.scan_start = !stat.best_v;
        cmd.mode = dtq_pkg::SM_MIN;
      end
      dtq_pkg::S_EMIT: begin
        cmd.emit = stat.out_free;
        cmd.scan_start = stat.out_free;
        cmd.mode = dtq_pkg::SM_SEL;
      end
      dtq_pkg::S_TICK_RESP: cmd.tick_done = stat.out_free;
      default: cmd.accept = 1'b0;
    endcase
  end
endmodule

FILE: hw/rtl/dtq_dp.sv
// Datapath: timer table, scan counter, accumulators and result register.
module dtq_dp #(
  parameter int N_TIMERS = dtq_pkg::N_TIMERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dtq_pkg::ctl_cmd_t            cmd,
  output dtq_pkg::dp_stat_t            stat,
  input  logic [dtq_pkg::ID_W-1:0]     in_timer_id,
  input  logic [dtq_pkg::TIME_W-1:0]   in_time_us,
  input  logic [dtq_pkg::IV_W-1:0]     in_interval_us,
  input  logic [dtq_pkg::DLY_W-1:0]    min_delay,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_kind,
  output logic [dtq_pkg::ID_W-1:0]     out_timer_id,
  output logic [1:0]                   out_status,
  output logic                         out_earliest_changed,
  output logic                         out_next_valid,
  output logic [dtq_pkg::TIME_W-1:0]   out_next_deadline,
  output logic [dtq_pkg::TIME_W-1:0]   out_reload_delay,
  output logic                         out_last
);
  localparam int IDX_W = (N_TIMERS > 1) ? $clog2(N_TIMERS) : 1;
  localparam int TW = dtq_pkg::TIME_W;
  localparam int IW = dtq_pkg::IV_W;
  localparam int DW = dtq_pkg::ID_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_TIMERS - 1);

  // Latched command operands.
  logic [DW-1:0] id_r;
  logic [TW-1:0] t_r;
  logic [IW-1:0] iv_r;
  dtq_pkg::scan_mode_t mode_r;

  // Scan sequencing.
  logic run_r, run_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic rdv_r, rdv_nxt;
  logic [IDX_W-1:0] ridx_r, ridx_nxt;

  logic [N_TIMERS-1:0] valid_r, valid_nxt;
  logic [N_TIMERS-1:0] pend_r, pend_nxt;

  // Accumulators.
  logic found_r, found_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic early_r, early_nxt;
  logic best_v_r, best_v_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [TW-1:0] best_dl_r, best_dl_nxt;
  logic [DW-1:0] best_id_r, best_id_nxt;
  logic [IW-1:0] best_iv_r, best_iv_nxt;
  logic nv_r, nv_nxt;
  logic [TW-1:0] nd_r, nd_nxt;

  // Result register.
  logic out_v_r, out_v_nxt;
  logic [1:0] kind_r;
  logic [DW-1:0] oid_r;
  logic [1:0] ost_r;
  logic early_o_r, nv_o_r, last_r;
  logic [TW-1:0] nd_o_r, rd_o_r;

  // Table memory.
  logic we;
  logic [IDX_W-1:0] waddr;
  logic [dtq_pkg::ENT_W-1:0] wdata, rdata;
  logic [TW-1:0] rd_dl;
  logic [IW-1:0] rd_iv;
  logic [DW-1:0] rd_id;

  logic out_free;
  logic proc, ent_v, dl_le_t;
  logic [TW:0] rearm_sum;
  logic [TW-1:0] rearm_dl;
  logic [TW-1:0] diff, raw_dly, reload;
  logic [1:0] add_st;

  dtq_ram #(.WIDTH(dtq_pkg::ENT_W), .DEPTH(N_TIMERS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(cnt_r), .rdata(rdata)
  );

  assign rd_dl = rdata[dtq_pkg::ENT_W-1 -: TW];
  assign rd_iv = rdata[DW +: IW];
  assign rd_id = rdata[DW-1:0];

  assign out_free = !out_v_r || out_ready;
  assign proc = rdv_r;
  assign ent_v = valid_r[ridx_r];
  assign dl_le_t = rd_dl <= t_r;

  assign rearm_sum = {1'b0, t_r} + (TW+1)'(best_iv_r);
  assign rearm_dl = rearm_sum[TW] ? {TW{1'b1}} : rearm_sum[TW-1:0];

  assign diff = nd_r - t_r;
  assign raw_dly = (nd_r > t_r) ? diff : '0;
  assign reload = (raw_dly < TW'(min_delay)) ? TW'(min_delay) : raw_dly;

  always_comb begin
    if (found_r) add_st = dtq_pkg::ST_DUP;
    else if (!free_r) add_st = dtq_pkg::ST_FULL;
    else add_st = dtq_pkg::ST_OK;
  end

  always_comb begin
    we = 1'b0;
    waddr = free_idx_r;
    wdata = {t_r, iv_r, id_r};
    if (cmd.add_commit && add_st == dtq_pkg::ST_OK) begin
      we = 1'b1;
    end else if (cmd.emit && best_iv_r != '0) begin
      we = 1'b1;
      waddr = best_idx_r;
      wdata = {rearm_dl, best_iv_r, best_id_r};
    end
  end

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    rdv_nxt = 1'b0;
    ridx_nxt = cnt_r;
    valid_nxt = valid_r;
    pend_nxt = pend_r;
    found_nxt = found_r;
    fidx_nxt = fidx_r;
    free_nxt = free_r;
    free_idx_nxt = free_idx_r;
    early_nxt = early_r;
    best_v_nxt = best_v_r;
    best_idx_nxt = best_idx_r;
    best_dl_nxt = best_dl_r;
    best_id_nxt = best_id_r;
    best_iv_nxt = best_iv_r;
    nv_nxt = nv_r;
    nd_nxt = nd_r;

    if (run_r) begin
      rdv_nxt = 1'b1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_IDX) run_nxt = 1'b0;
    end

    if (proc) begin
      case (mode_r)
        dtq_pkg::SM_ADD: begin
          if (ent_v && rd_id == id_r) found_nxt = 1'b1;
          if (ent_v && dl_le_t) early_nxt = 1'b0;
          if (!ent_v && !free_r) begin
            free_nxt = 1'b1;
            free_idx_nxt = ridx_r;
          end
        end
        dtq_pkg::SM_CAN: begin
          if (ent_v && rd_id == id_r && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt = ridx_r;
          end
        end
        dtq_pkg::SM_PEND: pend_nxt[ridx_r] = ent_v && dl_le_t;
        dtq_pkg::SM_SEL: begin
          if (pend_r[ridx_r] && (!best_v_r || rd_dl < best_dl_r ||
              (rd_dl == best_dl_r && rd_id < best_id_r))) begin
            best_v_nxt = 1'b1;
            best_idx_nxt = ridx_r;
            best_dl_nxt = rd_dl;
            best_id_nxt = rd_id;
            best_iv_nxt = rd_iv;
          end
        end
        dtq_pkg::SM_MIN: begin
          if (ent_v && (!nv_r || rd_dl < nd_r)) begin
            nv_nxt = 1'b1;
            nd_nxt = rd_dl;
          end
        end
        default: nv_nxt = nv_r;
      endcase
    end

    if (cmd.add_commit && add_st == dtq_pkg::ST_OK) valid_nxt[free_idx_r] = 1'b1;
    if (cmd.can_commit && found_r) valid_nxt[fidx_r] = 1'b0;
    if (cmd.emit) begin
      pend_nxt[best_idx_r] = 1'b0;
      if (best_iv_r == '0) valid_nxt[best_idx_r] = 1'b0;
    end

    if (cmd.scan_start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      case (cmd.mode)
        dtq_pkg::SM_ADD, dtq_pkg::SM_CAN: begin
          found_nxt = 1'b0;
          free_nxt = 1'b0;
          early_nxt = 1'b1;
        end
        dtq_pkg::SM_SEL: best_v_nxt = 1'b0;
        dtq_pkg::SM_MIN: nv_nxt = 1'b0;
        default: pend_nxt = pend_r;
      endcase
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_ready) out_v_nxt = 1'b0;
    if (cmd.add_commit || cmd.can_commit || cmd.emit || cmd.tick_done) out_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      rdv_r <= 1'b0;
      valid_r <= '0;
      out_v_r <= 1'b0;
      mode_r <= dtq_pkg::SM_ADD;
    end else begin
      run_r <= run_nxt;
      rdv_r <= rdv_nxt;
      valid_r <= valid_nxt;
      out_v_r <= out_v_nxt;
      if (cmd.scan_start) mode_r <= cmd.mode;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ridx_r <= ridx_nxt;
    pend_r <= pend_nxt;
    found_r <= found_nxt;
    fidx_r <= fidx_nxt;
    free_r <= free_nxt;
    free_idx_r <= free_idx_nxt;
    early_r <= early_nxt;
    best_v_r <= best_v_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r <= best_dl_nxt;
    best_id_r <= best_id_nxt;
    best_iv_r <= best_iv_nxt;
    nv_r <= nv_nxt;
    nd_r <= nd_nxt;
    if (cmd.accept) begin
      id_r <= in_timer_id;
      t_r <= in_time_us;
      iv_r <= in_interval_us;
    end
    if (cmd.add_commit || cmd.can_commit || cmd.emit || cmd.tick_done) begin
      kind_r <= dtq_pkg::KIND_ADD;
      oid_r <= id_r;
      ost_r <= dtq_pkg::ST_OK;
      early_o_r <= 1'b0;
      nv_o_r <= 1'b0;
      nd_o_r <= '0;
      rd_o_r <= '0;
      last_r <= 1'b1;
      if (cmd.add_commit) begin
        ost_r <= add_st;
        early_o_r <= (add_st == dtq_pkg::ST_OK) && early_r;
      end else if (cmd.can_commit) begin
        kind_r <= dtq_pkg::KIND_CANCEL;
        ost_r <= found_r ? dtq_pkg::ST_OK : dtq_pkg::ST_NOTFOUND;
      end else if (cmd.emit) begin
        kind_r <= dtq_pkg::KIND_EXPIRED;
        oid_r <= best_id_r;
        last_r <= 1'b0;
      end else begin
        kind_r <= dtq_pkg::KIND_DONE;
        oid_r <= '0;
        nv_o_r <= nv_r;
        nd_o_r <= nv_r ? nd_r : '0;
        rd_o_r <= nv_r ? reload : '0;
      end
    end
  end

  assign stat.scan_done = rdv_r && (ridx_r == LAST_IDX);
  assign stat.out_free = out_free;
  assign stat.best_v = best_v_r;

  assign out_valid = out_v_r;
  assign out_kind = kind_r;
  assign out_timer_id = oid_r;
  assign out_status = ost_r;
  assign out_earliest_changed = early_o_r;
  assign out_next_valid = nv_o_r;
  assign out_next_deadline = nd_o_r;
  assign out_reload_delay = rd_o_r;
  assign out_last = last_r;
endmodule
